// File: hdl/tssb_pkg.sv
package tssb_pkg;

   // Fixed field widths of the transaction ports
   localparam int CHAN_W      = 4;
   localparam int MASK_W      = 16;
   localparam int COUNT_W_MAX = 16;
   localparam int DELTA_W     = 17;

   // Parameter defaults
   localparam int NUM_CHANNELS_DEF = 16;
   localparam int COUNT_BITS_DEF   = 16;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_SCAN  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   // Response status codes
   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_CHANNEL = 2'd1,
      STAT_STRAY      = 2'd2
   } status_type;

   // Sequencing phase of the sensor
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CAL  = 2'd1,
      PH_SCAN = 2'd2
   } phase_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEEK,
      ST_RESP
   } state_type;

   // Channel search launch
   typedef struct packed {
      logic start;
      logic down;
   } seek_ctrl_type;

   // Channel search completion
   typedef struct packed {
      logic done;
      logic found;
   } seek_stat_type;

   // Count store write controls
   typedef struct packed {
      logic wr_raw;
      logic wr_base;
   } store_op_type;

endpackage

// File: hdl/tssb_chan_seek.sv
module tssb_chan_seek #(
   parameter int NCH  = 16,
   parameter int CH_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tssb_pkg::seek_ctrl_type ctrl,
   input  logic [CH_W-1:0]        first,
   input  logic [NCH-1:0]         mask,
   output tssb_pkg::seek_stat_type stat,
   output logic [CH_W-1:0]        chan
);
   import tssb_pkg::*;

   logic            busy_ff, busy_in;
   logic            down_ff, down_in;
   logic            done_ff, done_in;
   logic            found_ff, found_in;
   logic [CH_W-1:0] cand_ff, cand_in;

   // One candidate channel tested per cycle, inclusive of the first one
   always_comb begin
      busy_in  = busy_ff;
      down_in  = down_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      cand_in  = cand_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         down_in  = ctrl.down;
         cand_in  = first;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (mask[cand_ff]) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            found_in = 1'b1;
         end else if (down_ff) begin
            if (cand_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cand_in = cand_ff - 1'b1;
            end
         end else begin
            // ascending with wrap
            if (cand_ff == CH_W'(NCH - 1)) begin
               cand_in = '0;
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      down_ff <= down_in;
      cand_ff <= cand_in;
   end

   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign chan       = cand_ff;

endmodule

// File: hdl/tssb_count_store.sv
module tssb_count_store #(
   parameter int NCH        = 16,
   parameter int CH_W       = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tssb_pkg::store_op_type        op,
   input  logic [CH_W-1:0]               addr,
   input  logic [COUNT_BITS-1:0]         wr_data,
   output logic signed [tssb_pkg::DELTA_W-1:0] delta
);
   import tssb_pkg::*;

   logic [COUNT_BITS-1:0] raw_ff  [NCH];
   logic [COUNT_BITS-1:0] base_ff [NCH];
   logic [COUNT_BITS-1:0] raw_op;
   logic [COUNT_BITS-1:0] base_op;

   // Per-channel raw and baseline counts, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            raw_ff[i]  <= '0;
            base_ff[i] <= '0;
         end
      end else begin
         if (op.wr_raw) begin
            raw_ff[addr] <= wr_data;
         end
         if (op.wr_base) begin
            base_ff[addr] <= wr_data;
         end
      end
   end

   // Difference sees the count being written this cycle
   assign raw_op  = op.wr_raw  ? wr_data : raw_ff[addr];
   assign base_op = op.wr_base ? wr_data : base_ff[addr];
   assign delta   = DELTA_W'(raw_op) - DELTA_W'(base_op);

endmodule

// File: hdl/touch_scan_sequencer_baseline_unit.sv
// Touch scan sequencer with per-channel baseline. One transaction on req_
// gives exactly one transaction on rsp_. A start transaction begins a
// calibration sweep from the highest enabled channel down, storing each
// completed count as baseline; scanning then runs ascending round-robin
// from the lowest enabled channel, storing raw counts. A read returns raw
// minus baseline for one channel. csr_wr_data holds the channel enable mask;
// write it only while no transaction is in flight. After accept the
// sequencer runs an execute state; read and no-op transactions then go
// straight to the response, while scan and start transactions first run
// a channel search that tests one channel per cycle and then reports (a
// calibration sweep that finds no lower channel rolls over into an
// ascending search for scanning). The response register is loaded last.
// req_stall is high from accept until the response is loaded, and a
// pending response that is stalled holds the sequencer.
module touch_scan_sequencer_baseline_unit #(
   parameter int NUM_CHANNELS = tssb_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_BITS   = tssb_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [tssb_pkg::MASK_W-1:0]          csr_wr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [tssb_pkg::COUNT_W_MAX-1:0]     req_scan_count,
   input  logic [tssb_pkg::CHAN_W-1:0]          req_read_channel,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_start_scan,
   output logic [tssb_pkg::CHAN_W-1:0]          rsp_scan_channel,
   output logic signed [tssb_pkg::DELTA_W-1:0]  rsp_delta,
   output logic                                 rsp_calibrating
);
   import tssb_pkg::*;

   localparam int NCH_EFF = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
   localparam int CH_W    = (NCH_EFF > 1) ? $clog2(NCH_EFF) : 1;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [MASK_W-1:0]      csr_ff;
   func_type               func_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [CHAN_W-1:0]      rch_ff;
   logic [NCH_EFF-1:0]     mask_ff;
   logic [CH_W-1:0]        cur_ff, cur_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_start_ff, res_start_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic                   rsp_start_ff;
   logic [CHAN_W-1:0]      rsp_chan_ff;
   logic signed [DELTA_W-1:0] rsp_delta_ff;
   logic                   rsp_cal_ff;
   logic                   rsp_load;

   seek_ctrl_type          seek_ctrl;
   seek_stat_type          seek_stat;
   logic [CH_W-1:0]        seek_first;
   logic [CH_W-1:0]        seek_chan;

   store_op_type           store_op;
   logic [CH_W-1:0]        store_addr;
   logic signed [DELTA_W-1:0] store_delta;
   logic                   rch_in_range;
   logic                   req_accept;

   assign req_accept   = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign rch_in_range = ({1'b0, rch_ff} < (CHAN_W + 1)'(NCH_EFF));
   assign store_addr   = (func_ff == FUNC_READ) ? rch_ff[CH_W-1:0] : cur_ff;

   // Enable mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // Capture of the accepted transaction, mask taken live at accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff  <= func_type'(req_func);
         count_ff <= req_scan_count[COUNT_BITS-1:0];
         rch_ff   <= req_read_channel;
         mask_ff  <= csr_ff[NCH_EFF-1:0];
      end
   end

   tssb_chan_seek #(
      .NCH  (NCH_EFF),
      .CH_W (CH_W)
   ) u_seek (
      .clock (clock),
      .reset (reset),
      .ctrl  (seek_ctrl),
      .first (seek_first),
      .mask  (mask_ff),
      .stat  (seek_stat),
      .chan  (seek_chan)
   );

   tssb_count_store #(
      .NCH        (NCH_EFF),
      .CH_W       (CH_W),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .op      (store_op),
      .addr    (store_addr),
      .wr_data (count_ff),
      .delta   (store_delta)
   );

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      delta_in      = delta_ff;
      seek_ctrl     = '0;
      seek_first    = '0;
      store_op      = '0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_start_in  = 1'b0;
            delta_in      = '0;
            state_in      = ST_RESP;
            unique case (func_ff)
               FUNC_START: begin
                  if (mask_ff == '0) begin
                     res_status_in = STAT_NO_CHANNEL;
                     phase_in      = PH_IDLE;
                  end else begin
                     phase_in       = PH_CAL;
                     res_start_in   = 1'b1;
                     seek_ctrl.start = 1'b1;
                     seek_ctrl.down  = 1'b1;
                     seek_first     = CH_W'(NCH_EFF - 1);
                     state_in       = ST_SEEK;
                  end
               end
               FUNC_SCAN: begin
                  unique case (phase_ff)
                     PH_CAL: begin
                        store_op.wr_base = 1'b1;
                        delta_in         = store_delta;
                        if (mask_ff == '0) begin
                           res_status_in = STAT_NO_CHANNEL;
                           phase_in      = PH_IDLE;
                        end else begin
                           res_start_in    = 1'b1;
                           seek_ctrl.start = 1'b1;
                           state_in        = ST_SEEK;
                           if (cur_ff == '0) begin
                              // sweep done: scanning starts at lowest channel
                              phase_in       = PH_SCAN;
                              seek_ctrl.down = 1'b0;
                              seek_first     = '0;
                           end else begin
                              seek_ctrl.down = 1'b1;
                              seek_first     = cur_ff - 1'b1;
                           end
                        end
                     end
                     PH_SCAN: begin
                        store_op.wr_raw = 1'b1;
                        delta_in        = store_delta;
                        if (mask_ff == '0) begin
                           res_status_in = STAT_NO_CHANNEL;
                           phase_in      = PH_IDLE;
                        end else begin
                           res_start_in    = 1'b1;
                           seek_ctrl.start = 1'b1;
                           seek_ctrl.down  = 1'b0;
                           seek_first      = (cur_ff == CH_W'(NCH_EFF - 1)) ?
                                             '0 : cur_ff + 1'b1;
                           state_in        = ST_SEEK;
                        end
                     end
                     default: begin
                        res_status_in = STAT_STRAY;
                     end
                  endcase
               end
               FUNC_READ: begin
                  delta_in = rch_in_range ? store_delta : '0;
               end
               default: begin
               end
            endcase
         end
         ST_SEEK: begin
            if (seek_stat.done) begin
               if (seek_stat.found) begin
                  cur_in   = seek_chan;
                  state_in = ST_RESP;
               end else begin
                  // nothing lower left: switch to ascending scan
                  phase_in        = PH_SCAN;
                  seek_ctrl.start = 1'b1;
                  seek_ctrl.down  = 1'b0;
                  seek_first      = '0;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer and item state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
      end
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      delta_ff      <= delta_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_chan_ff   <= CHAN_W'(cur_ff);
         rsp_delta_ff  <= delta_ff;
         rsp_cal_ff    <= (phase_ff == PH_CAL);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_start_scan   = rsp_start_ff;
   assign rsp_scan_channel = rsp_chan_ff;
   assign rsp_delta        = rsp_delta_ff;
   assign rsp_calibrating  = rsp_cal_ff;

endmodule

// File: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tssb_pkg::*;

   localparam int DRAIN_CYCLES = 48;   // covers exec, a double channel search and the load
   localparam int RANDOM_ITEMS = 1050;

   // Expected fields of one response transaction
   typedef struct {
      status_type        status;
      logic              start_scan;
      logic [3:0]        channel;
      logic signed [16:0] delta;
      logic              calibrating;
   } scan_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [15:0]       csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_func;
   logic [15:0]       req_scan_count;
   logic [3:0]        req_read_channel;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_start_scan;
   logic [3:0]        rsp_scan_channel;
   logic signed [16:0] rsp_delta;
   logic              rsp_calibrating;

   // Sensor state as predicted from accepted transactions
   logic [15:0]       raw_shadow [16];
   logic [15:0]       baseline_counts [16];
   logic [3:0]        scan_ch;
   phase_type         seq_phase;
   logic [15:0]       enabled_mask;

   scan_result_type   awaited_responses [$];
   scan_result_type   oldest_response;
   int                mismatch_count = 0;
   int                items_sent = 0;
   int                hold_cnt = 0;
   bit                idle_on = 1'b1;

   touch_scan_sequencer_baseline_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_scan_count   (req_scan_count),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_start_scan   (rsp_start_scan),
      .rsp_scan_channel (rsp_scan_channel),
      .rsp_delta        (rsp_delta),
      .rsp_calibrating  (rsp_calibrating)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Channel search helpers; next_lower returns 16 when no channel is found
   function automatic int next_lower(logic [15:0] m, int below);
      for (int i = below - 1; i >= 0; i--)
         if (m[i]) return i;
      return 16;
   endfunction

   function automatic logic [3:0] next_up(logic [15:0] m, logic [3:0] from);
      logic [3:0] c;
      c = from;
      for (int i = 0; i < 16; i++) begin
         c = c + 4'd1;
         if (m[c]) return c;
      end
      return from;
   endfunction

   function automatic logic [3:0] lowest_enabled(logic [15:0] m);
      for (int i = 0; i < 16; i++)
         if (m[i]) return i[3:0];
      return 4'd0;
   endfunction

   function automatic logic signed [16:0] chan_delta(logic [3:0] ch);
      return {1'b0, raw_shadow[ch]} - {1'b0, baseline_counts[ch]};
   endfunction

   // Advance the predicted sensor state by one transaction
   function automatic scan_result_type advance_sequencer(func_type f, logic [15:0] cnt,
                                                         logic [3:0] rch);
      scan_result_type r;
      logic [3:0]      ch;
      int              nx;
      r.status     = STAT_OK;
      r.start_scan = 1'b0;
      r.delta      = '0;
      ch           = scan_ch;
      case (f)
         FUNC_START: begin
            if (enabled_mask == '0) begin
               r.status  = STAT_NO_CHANNEL;
               seq_phase = PH_IDLE;
            end else begin
               seq_phase    = PH_CAL;
               nx           = next_lower(enabled_mask, 16);
               scan_ch      = nx[3:0];
               r.start_scan = 1'b1;
            end
         end
         FUNC_SCAN: begin
            if (seq_phase == PH_CAL) begin
               baseline_counts[ch] = cnt;
               r.delta = chan_delta(ch);
               if (enabled_mask == '0) begin
                  r.status  = STAT_NO_CHANNEL;
                  seq_phase = PH_IDLE;
               end else begin
                  nx = next_lower(enabled_mask, int'(ch));
                  if (nx < 16) begin
                     scan_ch = nx[3:0];
                  end else begin
                     seq_phase = PH_SCAN;
                     scan_ch   = lowest_enabled(enabled_mask);
                  end
                  r.start_scan = 1'b1;
               end
            end else if (seq_phase == PH_SCAN) begin
               raw_shadow[ch] = cnt;
               r.delta = chan_delta(ch);
               if (enabled_mask == '0) begin
                  r.status  = STAT_NO_CHANNEL;
                  seq_phase = PH_IDLE;
               end else begin
                  scan_ch      = next_up(enabled_mask, ch);
                  r.start_scan = 1'b1;
               end
            end else begin
               r.status = STAT_STRAY;
            end
         end
         FUNC_READ: r.delta = chan_delta(rch);
         default: ;
      endcase
      r.channel     = scan_ch;
      r.calibrating = (seq_phase == PH_CAL);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Send one request transaction; returns at the falling edge after acceptance
   task automatic send_item(input func_type f, input logic [15:0] cnt, input logic [3:0] rch);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_scan_count   <= cnt;
      req_read_channel <= rch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_responses.push_back(advance_sequencer(f, cnt, rch));
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off until every response is in and the block has settled
   task automatic drain_responses;
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mask(input logic [15:0] m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      enabled_mask  = m;
   endtask

   function automatic logic [15:0] pick_count;
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Response checker: compares each transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            oldest_response = awaited_responses.pop_front();
            if (rsp_status !== oldest_response.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, oldest_response.status));
            if (rsp_start_scan !== oldest_response.start_scan)
               report_mismatch($sformatf("start_scan got %0b want %0b",
                                         rsp_start_scan, oldest_response.start_scan));
            if (rsp_scan_channel !== oldest_response.channel)
               report_mismatch($sformatf("scan_channel got %0d want %0d",
                                         rsp_scan_channel, oldest_response.channel));
            if (rsp_delta !== oldest_response.delta)
               report_mismatch($sformatf("delta got %0d want %0d",
                                         rsp_delta, oldest_response.delta));
            if (rsp_calibrating !== oldest_response.calibrating)
               report_mismatch($sformatf("calibrating got %0b want %0b",
                                         rsp_calibrating, oldest_response.calibrating));
         end
         hold_cnt = idle_on ? $urandom_range(0, 15) : 0;
      end
   end

   // Response stall: held for a drawn number of cycles after each transaction
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Empty mask after reset: start refused, scan is stray, reads return zero
   task automatic test_empty_mask;
      send_item(FUNC_START, 16'h0000, 4'd0);
      send_item(FUNC_SCAN, 16'h1234, 4'd0);
      send_item(FUNC_READ, 16'h0000, 4'd15);
      send_item(FUNC_NOP, 16'hFFFF, 4'd15);
   endtask

   // Two-channel sweep with count extremes, then full-range deltas
   task automatic test_sweep_extremes;
      drain_responses();
      write_mask(16'h8001);
      send_item(FUNC_START, 16'h0000, 4'd0);
      send_item(FUNC_SCAN, 16'hFFFF, 4'd0);
      send_item(FUNC_SCAN, 16'h0000, 4'd0);
      send_item(FUNC_SCAN, 16'hFFFF, 4'd0);
      send_item(FUNC_SCAN, 16'h0000, 4'd0);
      send_item(FUNC_READ, 16'h0000, 4'd0);
      send_item(FUNC_READ, 16'h0000, 4'd15);
      send_item(FUNC_READ, 16'h0000, 4'd7);
   endtask

   // Start while scanning restarts the sweep and keeps raw counts
   task automatic test_restart;
      send_item(FUNC_START, 16'h0000, 4'd0);
      send_item(FUNC_SCAN, 16'h5555, 4'd0);
      send_item(FUNC_NOP, 16'h0000, 4'd0);
   endtask

   // Mask emptied mid-sweep, then mask narrowed mid-sweep
   task automatic test_mask_changes;
      drain_responses();
      write_mask(16'h0000);
      send_item(FUNC_SCAN, 16'hAAAA, 4'd0);
      send_item(FUNC_SCAN, 16'h0001, 4'd0);
      drain_responses();
      write_mask(16'hFFFF);
      send_item(FUNC_START, 16'h0000, 4'd0);
      send_item(FUNC_SCAN, 16'hAAAA, 4'd0);
      drain_responses();
      write_mask(16'h0003);
      send_item(FUNC_SCAN, 16'h7FFF, 4'd0);
      send_item(FUNC_SCAN, 16'h8000, 4'd0);
      send_item(FUNC_READ, 16'h0000, 4'd1);
   endtask

   function automatic logic [15:0] pick_mask(int phase_no);
      if (phase_no % 9 == 8) return 16'h0000;
      case (phase_no % 6)
         0: return 16'hFFFF;
         1: return 16'h0001;
         2: return 16'h8000;
         4: return 16'($urandom & $urandom);
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   // Calibrate-then-scan sequences with random content, reads and some noise
   task automatic test_random;
      int phase_no;
      int n;
      int pick;
      bit remask;
      phase_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         drain_responses();
         idle_on = (phase_no % 4 != 3);
         write_mask(pick_mask(phase_no));
         send_item(FUNC_START, pick_count(), 4'($urandom_range(0, 15)));
         n      = $countones(enabled_mask) + $urandom_range(0, 30);
         remask = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) begin
            if (remask && i == n / 2) begin
               drain_responses();
               write_mask(pick_mask($urandom_range(0, 17)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
               send_item(FUNC_SCAN, pick_count(), 4'($urandom_range(0, 15)));
            else if (pick < 88)
               send_item(FUNC_READ, pick_count(), 4'($urandom_range(0, 15)));
            else if (pick < 94)
               send_item(FUNC_START, pick_count(), 4'($urandom_range(0, 15)));
            else
               send_item(FUNC_NOP, pick_count(), 4'($urandom_range(0, 15)));
         end
         phase_no++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_func         = FUNC_NOP;
      req_scan_count   = '0;
      req_read_channel = '0;
      for (int i = 0; i < 16; i++) begin
         raw_shadow[i]      = '0;
         baseline_counts[i] = '0;
      end
      scan_ch      = '0;
      seq_phase    = PH_IDLE;
      enabled_mask = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_mask();
      test_sweep_extremes();
      test_restart();
      test_mask_changes();
      test_random();
      drain_responses();

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Run limit, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
